// ===== hdl/vscb_pkg.sv =====
// ----------------------------------------------------------------------------
// vscb_pkg
// Shared widths, register map, sideband types and saturation helper for the
// Verlet substep with circular bound.
// ----------------------------------------------------------------------------
package vscb_pkg;

  localparam int POS_W     = 24;
  localparam int DIFF_W    = 25;
  localparam int LIM_W     = 23;
  localparam int DSQ_W     = 50;
  localparam int PROD_W    = 48;
  localparam int GQ_W      = 30;
  localparam int SQ_STEPS  = DSQ_W / 2;   // one root bit per stage
  localparam int ROOT_W    = SQ_STEPS;
  localparam int SQREM_W   = ROOT_W + 1;
  localparam int QUO_W     = 24;          // quotient stays below 2^24
  localparam int NUM_W     = PROD_W + 1;
  localparam int ADDR_W    = 5;

  localparam logic [ADDR_W-1:0] ADDR_DT   = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] ADDR_GRAV = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] ADDR_CX   = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] ADDR_CY   = ADDR_W'(12);
  localparam logic [ADDR_W-1:0] ADDR_BRAD = ADDR_W'(16);

  localparam logic [31:0]             RST_DT   = 32'd33140;
  localparam logic signed [15:0]      RST_GRAV = 16'sd500;
  localparam logic signed [POS_W-1:0] RST_CX   = 24'sd4096000;
  localparam logic signed [POS_W-1:0] RST_CY   = 24'sd2048000;
  localparam logic [LIM_W-1:0]        RST_BRAD = 23'd2048000;

  // item sideband that rides along the root and divide pipelines
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] qx;
    logic signed [POS_W-1:0] qy;
    logic                    sx;     // dx negative
    logic                    sy;     // dy negative
    logic                    clamp;
    logic signed [GQ_W-1:0]  gq;     // rounded gravity term
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [PROD_W-1:0]  mx;          // |dx| * limit
    logic [PROD_W-1:0]  my;          // |dy| * limit
  } sq_side_t;

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd8388607;
    lo = -32'sd8388608;
    if (v > hi) begin
      return 24'sh7FFFFF;
    end else if (v < lo) begin
      return 24'sh800000;
    end
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== hdl/vscb_front.sv =====
// ----------------------------------------------------------------------------
// vscb_front
// Three-stage front end: offsets, squares and products, bound compare and
// rounded gravity term.
// ----------------------------------------------------------------------------
module vscb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [vscb_pkg::POS_W-1:0] pos_x,
  input  logic signed [vscb_pkg::POS_W-1:0] pos_y,
  input  logic signed [vscb_pkg::POS_W-1:0] prev_x,
  input  logic signed [vscb_pkg::POS_W-1:0] prev_y,
  input  logic [19:0]                       prad,
  input  logic [31:0]                       dt_sq,
  input  logic signed [15:0]                grav,
  input  logic signed [vscb_pkg::POS_W-1:0] cen_x,
  input  logic signed [vscb_pkg::POS_W-1:0] cen_y,
  input  logic [vscb_pkg::LIM_W-1:0]        brad,
  output logic                              out_vld,
  output logic [vscb_pkg::DSQ_W-1:0]        dsq,
  output vscb_pkg::sq_side_t                sq_side
);

  localparam int DIFF_W = vscb_pkg::DIFF_W;

  // stage 1
  logic                               v1_r;
  logic [vscb_pkg::DIFF_W-1:0]        ax1_r, ay1_r;
  logic [vscb_pkg::LIM_W-1:0]         lim1_r;
  vscb_pkg::side_t                    s1_r;
  logic signed [vscb_pkg::DIFF_W-1:0] dx, dy;
  logic signed [vscb_pkg::LIM_W:0]    lim_s;

  assign dx    = DIFF_W'(pos_x) - DIFF_W'(cen_x);
  assign dy    = DIFF_W'(pos_y) - DIFF_W'(cen_y);
  assign lim_s = $signed({1'b0, brad}) - $signed({4'b0, prad});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
    ax1_r    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay1_r    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    lim1_r   <= lim_s[vscb_pkg::LIM_W] ? '0 : lim_s[vscb_pkg::LIM_W-1:0];
    s1_r.px  <= pos_x;
    s1_r.py  <= pos_y;
    s1_r.qx  <= prev_x;
    s1_r.qy  <= prev_y;
    s1_r.sx  <= dx[DIFF_W-1];
    s1_r.sy  <= dy[DIFF_W-1];
    s1_r.clamp <= 1'b0;
    s1_r.gq  <= '0;
  end

  // stage 2: multipliers
  logic                       v2_r;
  logic [2*DIFF_W-1:0]        sqx2_r, sqy2_r;
  logic [2*vscb_pkg::LIM_W-1:0] lsq2_r;
  logic [vscb_pkg::PROD_W-1:0]  mx2_r, my2_r;
  logic signed [48:0]           gp2_r;
  vscb_pkg::side_t              s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    sqx2_r <= ax1_r * ax1_r;
    sqy2_r <= ay1_r * ay1_r;
    lsq2_r <= lim1_r * lim1_r;
    mx2_r  <= ax1_r * lim1_r;
    my2_r  <= ay1_r * lim1_r;
    gp2_r  <= grav * $signed({1'b0, dt_sq});
    s2_r   <= s1_r;
  end

  // stage 3: distance compare, gravity rounding
  logic [vscb_pkg::DSQ_W-1:0] dsq_sum;
  logic [47:0]                gmag;
  logic [28:0]                gq_mag;
  vscb_pkg::side_t            side3_nxt;
  logic                       v3_r;
  logic [vscb_pkg::DSQ_W-1:0] dsq3_r;
  vscb_pkg::sq_side_t         sq3_r;

  assign dsq_sum = sqx2_r + sqy2_r;
  assign gmag    = gp2_r[48] ? 48'(-gp2_r) : 48'(gp2_r);
  assign gq_mag  = 29'((49'(gmag) + 49'(1 << 19)) >> 20);

  always_comb begin
    side3_nxt       = s2_r;
    side3_nxt.clamp = (dsq_sum != '0) && (dsq_sum > vscb_pkg::DSQ_W'(lsq2_r));
    side3_nxt.gq    = gp2_r[48] ? -$signed({1'b0, gq_mag}) : $signed({1'b0, gq_mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    dsq3_r     <= dsq_sum;
    sq3_r.side <= side3_nxt;
    sq3_r.mx   <= mx2_r;
    sq3_r.my   <= my2_r;
  end

  assign out_vld = v3_r;
  assign dsq     = dsq3_r;
  assign sq_side = sq3_r;

endmodule

// ===== hdl/vscb_sqrt.sv =====
// ----------------------------------------------------------------------------
// vscb_sqrt
// Pipelined integer square root, one root bit per stage (floor).
// ----------------------------------------------------------------------------
module vscb_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [vscb_pkg::DSQ_W-1:0]    dsq,
  input  vscb_pkg::sq_side_t            in_side,
  output logic                          out_vld,
  output logic [vscb_pkg::ROOT_W-1:0]   root,
  output vscb_pkg::sq_side_t            out_side
);

  localparam int N  = vscb_pkg::SQ_STEPS;
  localparam int RW = vscb_pkg::ROOT_W;
  localparam int MW = vscb_pkg::SQREM_W;
  localparam int DW = vscb_pkg::DSQ_W;

  logic               vld_r  [0:N];
  logic [MW-1:0]      rem_r  [0:N];
  logic [RW-1:0]      root_r [0:N];
  logic [DW-1:0]      nb_r   [0:N];
  vscb_pkg::sq_side_t side_r [0:N];

  always_comb begin
    vld_r[0]  = in_vld;
    rem_r[0]  = '0;
    root_r[0] = '0;
    nb_r[0]   = dsq;
    side_r[0] = in_side;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [MW:0] rsh, trial, diff;
    logic        take;
    assign rsh   = {rem_r[i][MW-2:0], nb_r[i][DW-1:DW-2]};
    assign trial = {root_r[i][RW-2:0], 2'b01};
    assign take  = rsh >= trial;
    assign diff  = rsh - trial;
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
      rem_r[i+1]  <= take ? diff[MW-1:0] : rsh[MW-1:0];
      root_r[i+1] <= {root_r[i][RW-2:0], take};
      nb_r[i+1]   <= {nb_r[i][DW-3:0], 2'b00};
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_vld  = vld_r[N];
  assign root     = root_r[N];
  assign out_side = side_r[N];

endmodule

// ===== hdl/vscb_div.sv =====
// ----------------------------------------------------------------------------
// vscb_div
// Two-lane pipelined restoring divider: round(|d|*limit / distance), one
// quotient bit per stage, after a rounding-bias stage.
// ----------------------------------------------------------------------------
module vscb_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [vscb_pkg::ROOT_W-1:0]  dlen,
  input  vscb_pkg::sq_side_t           in_side,
  output logic                         out_vld,
  output logic [vscb_pkg::QUO_W-1:0]   quo_x,
  output logic [vscb_pkg::QUO_W-1:0]   quo_y,
  output vscb_pkg::side_t              out_side
);

  localparam int N  = vscb_pkg::QUO_W;
  localparam int RW = vscb_pkg::ROOT_W;
  localparam int NW = vscb_pkg::NUM_W;

  // bias stage
  logic              v0_r;
  logic [NW-1:0]     num0_r [0:1];
  logic [RW-1:0]     dist0_r;
  vscb_pkg::side_t   side0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= in_vld;
    num0_r[0] <= NW'(in_side.mx) + NW'(dlen >> 1);
    num0_r[1] <= NW'(in_side.my) + NW'(dlen >> 1);
    dist0_r   <= dlen;
    side0_r   <= in_side.side;
  end

  logic            vld_r  [0:N];
  logic [RW-1:0]   dist_r [0:N];
  vscb_pkg::side_t side_r [0:N];
  logic [RW-1:0]   rem_r  [0:1][0:N];
  logic [N-1:0]    low_r  [0:1][0:N];
  logic [N-1:0]    quo_r  [0:1][0:N];

  always_comb begin
    vld_r[0]    = v0_r;
    dist_r[0]   = dist0_r;
    side_r[0]   = side0_r;
    rem_r[0][0] = num0_r[0][NW-1:N];
    rem_r[1][0] = num0_r[1][NW-1:N];
    low_r[0][0] = num0_r[0][N-1:0];
    low_r[1][0] = num0_r[1][N-1:0];
    quo_r[0][0] = '0;
    quo_r[1][0] = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
      dist_r[i+1] <= dist_r[i];
      side_r[i+1] <= side_r[i];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW:0] rsh, diff;
      logic        take;
      assign rsh  = {rem_r[l][i], low_r[l][i][N-1]};
      assign take = rsh >= {1'b0, dist_r[i]};
      assign diff = rsh - {1'b0, dist_r[i]};
      always_ff @(posedge clk) begin
        rem_r[l][i+1] <= take ? diff[RW-1:0] : rsh[RW-1:0];
        low_r[l][i+1] <= {low_r[l][i][N-2:0], 1'b0};
        quo_r[l][i+1] <= {quo_r[l][i][N-2:0], take};
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign quo_x    = quo_r[0][N];
  assign quo_y    = quo_r[1][N];
  assign out_side = side_r[N];

endmodule

// ===== hdl/vscb_back.sv =====
// ----------------------------------------------------------------------------
// vscb_back
// Two-stage back end: constrained position, then Verlet update with
// saturation.
// ----------------------------------------------------------------------------
module vscb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [vscb_pkg::QUO_W-1:0]        quo_x,
  input  logic [vscb_pkg::QUO_W-1:0]        quo_y,
  input  vscb_pkg::side_t                   in_side,
  input  logic signed [vscb_pkg::POS_W-1:0] cen_x,
  input  logic signed [vscb_pkg::POS_W-1:0] cen_y,
  output logic                              out_vld,
  output logic signed [vscb_pkg::POS_W-1:0] nx,
  output logic signed [vscb_pkg::POS_W-1:0] ny,
  output logic signed [vscb_pkg::POS_W-1:0] cx,
  output logic signed [vscb_pkg::POS_W-1:0] cy,
  output logic                              clamped
);

  logic signed [31:0] offx, offy;
  logic               v1_r;
  logic signed [vscb_pkg::POS_W-1:0] cx1_r, cy1_r, qx1_r, qy1_r;
  logic signed [vscb_pkg::GQ_W-1:0]  gq1_r;
  logic               cl1_r;

  assign offx = in_side.sx ? -$signed({8'b0, quo_x}) : $signed({8'b0, quo_x});
  assign offy = in_side.sy ? -$signed({8'b0, quo_y}) : $signed({8'b0, quo_y});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
    cx1_r <= in_side.clamp ? vscb_pkg::sat24(32'(cen_x) + offx) : in_side.px;
    cy1_r <= in_side.clamp ? vscb_pkg::sat24(32'(cen_y) + offy) : in_side.py;
    qx1_r <= in_side.qx;
    qy1_r <= in_side.qy;
    gq1_r <= in_side.gq;
    cl1_r <= in_side.clamp;
  end

  logic               v2_r;
  logic signed [vscb_pkg::POS_W-1:0] nx2_r, ny2_r, cx2_r, cy2_r;
  logic               cl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    nx2_r <= vscb_pkg::sat24(32'(cx1_r) * 2 - 32'(qx1_r));
    ny2_r <= vscb_pkg::sat24(32'(cy1_r) * 2 - 32'(qy1_r) + 32'(gq1_r));
    cx2_r <= cx1_r;
    cy2_r <= cy1_r;
    cl2_r <= cl1_r;
  end

  assign out_vld = v2_r;
  assign nx      = nx2_r;
  assign ny      = ny2_r;
  assign cx      = cx2_r;
  assign cy      = cy2_r;
  assign clamped = cl2_r;

endmodule

// ===== hdl/verlet_step_circle_bound.sv =====
// ----------------------------------------------------------------------------
// verlet_step_circle_bound
// One position-Verlet substep per particle word, with projection onto a
// circular boundary, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  input    | in_pos_*, in_prev_*, in_particle_radius | start & !busy
//  result   | out_next_*, out_next_prev_*, out_was_.. | out_strobe, 1 cycle
//  config   | psel penable pwrite paddr pwdata prdata | APB, pready = 1
//
// A word is taken every cycle (busy is tied low). Pipeline stages, in order:
// 3 front stages, 25 square-root stages (one root bit each), 1 bias stage
// plus 24 divider stages (one quotient bit each), 2 back stages.
// Synchronous active-low reset clears the valid chain and loads register
// defaults. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module verlet_step_circle_bound (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [vscb_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [vscb_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [vscb_pkg::POS_W-1:0] in_prev_x,
  input  logic signed [vscb_pkg::POS_W-1:0] in_prev_y,
  input  logic [19:0]                       in_particle_radius,
  output logic                              out_strobe,
  output logic signed [vscb_pkg::POS_W-1:0] out_next_x,
  output logic signed [vscb_pkg::POS_W-1:0] out_next_y,
  output logic signed [vscb_pkg::POS_W-1:0] out_next_prev_x,
  output logic signed [vscb_pkg::POS_W-1:0] out_next_prev_y,
  output logic                              out_was_clamped,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vscb_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // configuration registers
  logic [31:0]                       dt_r;
  logic signed [15:0]                grav_r;
  logic signed [vscb_pkg::POS_W-1:0] cx_r, cy_r;
  logic [vscb_pkg::LIM_W-1:0]        brad_r;
  logic                              wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r   <= vscb_pkg::RST_DT;
      grav_r <= vscb_pkg::RST_GRAV;
      cx_r   <= vscb_pkg::RST_CX;
      cy_r   <= vscb_pkg::RST_CY;
      brad_r <= vscb_pkg::RST_BRAD;
    end else if (wr_en) begin
      unique case (paddr)
        vscb_pkg::ADDR_DT:   dt_r   <= pwdata;
        vscb_pkg::ADDR_GRAV: grav_r <= pwdata[15:0];
        vscb_pkg::ADDR_CX:   cx_r   <= pwdata[23:0];
        vscb_pkg::ADDR_CY:   cy_r   <= pwdata[23:0];
        vscb_pkg::ADDR_BRAD: brad_r <= pwdata[22:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      vscb_pkg::ADDR_DT:   prdata = dt_r;
      vscb_pkg::ADDR_GRAV: prdata = 32'(grav_r);
      vscb_pkg::ADDR_CX:   prdata = 32'(cx_r);
      vscb_pkg::ADDR_CY:   prdata = 32'(cy_r);
      vscb_pkg::ADDR_BRAD: prdata = {9'b0, brad_r};
      default:             prdata = '0;
    endcase
  end

  // front: offsets, squares, bound test, gravity term
  logic                        f_vld;
  logic [vscb_pkg::DSQ_W-1:0]  f_dsq;
  vscb_pkg::sq_side_t          f_side;

  vscb_front u_front (
    .clk, .rst_n,
    .in_vld (start && !busy),
    .pos_x  (in_pos_x),
    .pos_y  (in_pos_y),
    .prev_x (in_prev_x),
    .prev_y (in_prev_y),
    .prad   (in_particle_radius),
    .dt_sq  (dt_r),
    .grav   (grav_r),
    .cen_x  (cx_r),
    .cen_y  (cy_r),
    .brad   (brad_r),
    .out_vld(f_vld),
    .dsq    (f_dsq),
    .sq_side(f_side)
  );

  // distance = floor(sqrt(dsq))
  logic                        s_vld;
  logic [vscb_pkg::ROOT_W-1:0] s_root;
  vscb_pkg::sq_side_t          s_side;

  vscb_sqrt u_sqrt (
    .clk, .rst_n,
    .in_vld  (f_vld),
    .dsq     (f_dsq),
    .in_side (f_side),
    .out_vld (s_vld),
    .root    (s_root),
    .out_side(s_side)
  );

  // offset magnitudes = round(|d| * limit / distance)
  logic                       d_vld;
  logic [vscb_pkg::QUO_W-1:0] d_qx, d_qy;
  vscb_pkg::side_t            d_side;

  vscb_div u_div (
    .clk, .rst_n,
    .in_vld  (s_vld),
    .dlen    (s_root),
    .in_side (s_side),
    .out_vld (d_vld),
    .quo_x   (d_qx),
    .quo_y   (d_qy),
    .out_side(d_side)
  );

  // projection and Verlet update
  vscb_back u_back (
    .clk, .rst_n,
    .in_vld (d_vld),
    .quo_x  (d_qx),
    .quo_y  (d_qy),
    .in_side(d_side),
    .cen_x  (cx_r),
    .cen_y  (cy_r),
    .out_vld(out_strobe),
    .nx     (out_next_x),
    .ny     (out_next_y),
    .cx     (out_next_prev_x),
    .cy     (out_next_prev_y),
    .clamped(out_was_clamped)
  );

  // never back-pressures the source
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  // a write to the step register lands in dt_r
  a_dt_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && paddr == vscb_pkg::ADDR_DT |=> dt_r == $past(pwdata))
    else $error("dt_squared write lost");

  // reset empties the pipeline
  a_rst_flush: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result after reset");

endmodule
